// File: design/rmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int Q_W    = 16;  // Q2.14 field width
  localparam int DIAG_W = 17;  // clamped diagonal term, unsigned
  localparam int PAIR_W = 17;  // off-diagonal pair sum or difference, signed
  localparam int ROOT_W = 15;  // pivot magnitude
  localparam int RAD_W  = 30;  // radicand: diagonal term times 4096
  localparam int DEN_W  = 16;  // divisor: twice the pivot magnitude
  localparam int LANES  = 3;   // off-diagonal components per transaction

  localparam logic signed [17:0] Q_ONE = 18'sd16384;
  localparam logic signed [15:0] Q_MAX = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic [DIAG_W-1:0]        diag_t;

  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } piv_t;

  // Side data carried through the square root pipe
  typedef struct packed {
    pair_t [LANES-1:0] n;
    piv_t              piv;
    logic              degen;
  } sqrt_tag_t;

  // Side data carried through the divider pipe
  typedef struct packed {
    piv_t              piv;
    logic              degen;
    logic [ROOT_W-1:0] p;
  } div_tag_t;

endpackage
`default_nettype wire

// File: design/rmq_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// Integer square root, one result bit per register stage, with a side tag.
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
  parameter int TAG_W = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic [rmq_pkg::RAD_W-1:0]  in_rad,
  input  wire logic [TAG_W-1:0]          in_tag,
  output logic                           out_vld,
  output logic [rmq_pkg::ROOT_W-1:0]     out_root,
  output logic [TAG_W-1:0]               out_tag
);
  import rmq_pkg::*;

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [STEPS];
  logic [RAD_W-1:0]  rad_r  [STEPS];
  logic [ROOT_W-1:0] root_r [STEPS];
  logic [REM_W-1:0]  rem_r  [STEPS];
  logic [TAG_W-1:0]  tag_r  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [TAG_W-1:0]  tag_in;
    logic [REM_W+1:0]  ext;
    logic [REM_W+1:0]  trial;
    logic              fits;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign root_in = '0;
      assign rem_in  = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign rad_in  = rad_r[j-1];
      assign root_in = root_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign tag_in  = tag_r[j-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign ext   = {rem_in, rad_in[2*(STEPS-1-j)+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fits  = (ext >= trial);

    always_comb begin
      if (fits) begin
        rem_nxt  = REM_W'(ext - trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = ext[REM_W-1:0];
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= rad_in;
        root_r[j] <= root_nxt;
        rem_r[j]  <= rem_nxt;
        tag_r[j]  <= tag_in;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1];
  assign out_tag  = tag_r[STEPS-1];

endmodule
`default_nettype wire

// File: design/rmq_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Three lane restoring divider: n*4096/p, rounded half away, saturated.
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
  parameter int TAG_W = 1
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       en,
  input  wire logic                                       in_vld,
  input  wire rmq_pkg::pair_t [rmq_pkg::LANES-1:0]        in_n,
  input  wire logic [rmq_pkg::ROOT_W-1:0]                 in_p,
  input  wire logic [TAG_W-1:0]                           in_tag,
  output logic                                            out_vld,
  output logic signed [rmq_pkg::LANES-1:0][rmq_pkg::Q_W-1:0] out_q,
  output logic [TAG_W-1:0]                                out_tag
);
  import rmq_pkg::*;

  localparam int QB    = Q_W - 1;  // quotient bits below saturation
  localparam int STEPS = QB;

  // setup stage
  logic                         s0_vld_r;
  logic [DEN_W-1:0]             s0_den_r;
  logic [TAG_W-1:0]             s0_tag_r;
  logic [LANES-1:0][RAD_W-1:0]  s0_num_r;
  logic [LANES-1:0][DEN_W-1:0]  s0_rem_r;
  logic [LANES-1:0]             s0_neg_r;
  logic [LANES-1:0]             s0_ovf_r;

  logic [DEN_W-1:0]             den_nxt;
  logic [LANES-1:0][RAD_W-1:0]  num_nxt;
  logic [LANES-1:0][DEN_W-1:0]  rem_init_nxt;
  logic [LANES-1:0]             neg_nxt;
  logic [LANES-1:0]             ovf_nxt;

  assign den_nxt = {in_p, 1'b0};

  for (genvar l = 0; l < LANES; l++) begin : g_setup
    logic [PAIR_W-1:0] mag;
    assign neg_nxt[l] = in_n[l][PAIR_W-1];
    assign mag        = neg_nxt[l] ? PAIR_W'(-in_n[l]) : PAIR_W'(in_n[l]);
    // numerator carries the rounding term p
    assign num_nxt[l] = {mag, 13'b0} + RAD_W'(in_p);
    assign ovf_nxt[l] = ({1'b0, num_nxt[l]} >= {den_nxt, 15'b0});
    assign rem_init_nxt[l] = {1'b0, num_nxt[l][RAD_W-1:QB]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_den_r <= den_nxt;
      s0_tag_r <= in_tag;
      s0_num_r <= num_nxt;
      s0_rem_r <= rem_init_nxt;
      s0_neg_r <= neg_nxt;
      s0_ovf_r <= ovf_nxt;
    end
  end

  // quotient stages
  logic                        vld_r [STEPS];
  logic [DEN_W-1:0]            den_r [STEPS];
  logic [TAG_W-1:0]            tag_r [STEPS];
  logic [LANES-1:0][RAD_W-1:0] num_r [STEPS];
  logic [LANES-1:0][DEN_W-1:0] rem_r [STEPS];
  logic [LANES-1:0][QB-1:0]    q_r   [STEPS];
  logic [LANES-1:0]            neg_r [STEPS];
  logic [LANES-1:0]            ovf_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                        vld_in;
    logic [DEN_W-1:0]            den_in;
    logic [TAG_W-1:0]            tag_in;
    logic [LANES-1:0][RAD_W-1:0] num_in;
    logic [LANES-1:0][DEN_W-1:0] rem_in;
    logic [LANES-1:0][QB-1:0]    q_in;
    logic [LANES-1:0]            neg_in;
    logic [LANES-1:0]            ovf_in;
    logic [LANES-1:0][DEN_W-1:0] rem_nxt;
    logic [LANES-1:0][QB-1:0]    q_nxt;

    if (k == 0) begin : g_first
      assign vld_in = s0_vld_r;
      assign den_in = s0_den_r;
      assign tag_in = s0_tag_r;
      assign num_in = s0_num_r;
      assign rem_in = s0_rem_r;
      assign q_in   = '0;
      assign neg_in = s0_neg_r;
      assign ovf_in = s0_ovf_r;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
      assign num_in = num_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign neg_in = neg_r[k-1];
      assign ovf_in = ovf_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] t;
      logic           fits;
      assign t    = {rem_in[l], num_in[l][STEPS-1-k]};
      assign fits = (t >= {1'b0, den_in});
      assign rem_nxt[l] = fits ? DEN_W'(t - {1'b0, den_in}) : t[DEN_W-1:0];
      assign q_nxt[l]   = {q_in[l][QB-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        tag_r[k] <= tag_in;
        num_r[k] <= num_in;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        neg_r[k] <= neg_in;
        ovf_r[k] <= ovf_in;
      end
    end
  end

  // sign and saturate
  for (genvar l = 0; l < LANES; l++) begin : g_sat
    logic signed [Q_W-1:0] pos;
    assign pos = signed'({1'b0, q_r[STEPS-1][l]});
    always_comb begin
      if (neg_r[STEPS-1][l]) begin
        out_q[l] = ovf_r[STEPS-1][l] ? Q_MIN : Q_W'(-pos);
      end else begin
        out_q[l] = ovf_r[STEPS-1][l] ? Q_MAX : pos;
      end
    end
  end

  assign out_vld = vld_r[STEPS-1];
  assign out_tag = tag_r[STEPS-1];

endmodule
`default_nettype wire

// File: design/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a right/up/forward basis (Q2.14) to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with nine Q2.14 basis components. A
//   transaction is taken when in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with quat_w..z, pivot_index and
//   degenerate. A result is taken when out_valid is high and out_stall low.
// Throughput: one transaction per cycle, sustained and with no gaps, unless the output is held.
// Pipeline: from acceptance to out_valid a result passes stage A, stage B, the 15-stage
//   bit-serial square root, the 16-stage three-lane divider and the output register.
// Stall: the whole pipeline holds in place while a result sits in the output
//   register and out_stall is high; in_stall is raised in the same cycles, so
//   nothing is dropped or repeated. Empty stages do not advance on their own.
// Reset: rst_n (synchronous, active low) clears every valid bit; data
//   registers carry no reset. The block keeps no state between transactions.
// Degenerate basis: when all diagonal terms clamp to zero, the quaternion is
//   all zeros, pivot_index is x and degenerate is set.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_right_x,
  input  wire logic signed [15:0] in_right_y,
  input  wire logic signed [15:0] in_right_z,
  input  wire logic signed [15:0] in_up_x,
  input  wire logic signed [15:0] in_up_y,
  input  wire logic signed [15:0] in_up_z,
  input  wire logic signed [15:0] in_fwd_x,
  input  wire logic signed [15:0] in_fwd_y,
  input  wire logic signed [15:0] in_fwd_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_quat_w,
  output logic signed [15:0]      out_quat_x,
  output logic signed [15:0]      out_quat_y,
  output logic signed [15:0]      out_quat_z,
  output logic [1:0]              out_pivot_index,
  output logic                    out_degenerate
);
  import rmq_pkg::*;

  logic out_valid_r;

  // Advance the whole pipeline unless a finished result is being held
  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- Stage A: diagonal terms and off-diagonal pairs ----------
  logic        a_vld_r;
  diag_t [3:0] a_d_r;
  pair_t       a_s_xy_r, a_s_xz_r, a_s_yz_r, a_d_wx_r, a_d_wy_r, a_d_wz_r;

  logic signed [17:0] rx, uy, fz;
  logic signed [17:0] raw [4];
  diag_t [3:0]        d_nxt;

  assign rx = 18'(in_right_x);
  assign uy = 18'(in_up_y);
  assign fz = 18'(in_fwd_z);

  assign raw[0] = Q_ONE + rx - uy - fz;
  assign raw[1] = Q_ONE + uy - rx - fz;
  assign raw[2] = Q_ONE + fz - rx - uy;
  assign raw[3] = Q_ONE + rx + uy + fz;

  for (genvar i = 0; i < 4; i++) begin : g_clamp
    assign d_nxt[i] = raw[i][17] ? '0 : raw[i][DIAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r    <= d_nxt;
      a_s_xy_r <= PAIR_W'(in_right_y) + PAIR_W'(in_up_x);
      a_s_xz_r <= PAIR_W'(in_fwd_x)   + PAIR_W'(in_right_z);
      a_s_yz_r <= PAIR_W'(in_up_z)    + PAIR_W'(in_fwd_y);
      a_d_wx_r <= PAIR_W'(in_up_z)    - PAIR_W'(in_fwd_y);
      a_d_wy_r <= PAIR_W'(in_fwd_x)   - PAIR_W'(in_right_z);
      a_d_wz_r <= PAIR_W'(in_right_y) - PAIR_W'(in_up_x);
    end
  end

  // ---------------- Stage B: pivot pick and lane routing --------------------
  logic      b_vld_r;
  diag_t     b_best_r;
  sqrt_tag_t b_tag_r;

  diag_t             best_nxt;
  piv_t              piv_nxt;
  pair_t [LANES-1:0] n_nxt;

  always_comb begin
    // strict greater-than keeps the earlier term on ties
    best_nxt = a_d_r[0];
    piv_nxt  = PIV_X;
    if (a_d_r[1] > best_nxt) begin
      best_nxt = a_d_r[1];
      piv_nxt  = PIV_Y;
    end
    if (a_d_r[2] > best_nxt) begin
      best_nxt = a_d_r[2];
      piv_nxt  = PIV_Z;
    end
    if (a_d_r[3] > best_nxt) begin
      best_nxt = a_d_r[3];
      piv_nxt  = PIV_W;
    end
  end

  // Lanes hold the three non-pivot components in x, y, z, w order
  always_comb begin
    unique case (piv_nxt)
      PIV_X: n_nxt = {a_d_wx_r, a_s_xz_r, a_s_xy_r};
      PIV_Y: n_nxt = {a_d_wy_r, a_s_yz_r, a_s_xy_r};
      PIV_Z: n_nxt = {a_d_wz_r, a_s_yz_r, a_s_xz_r};
      default: n_nxt = {a_d_wz_r, a_d_wy_r, a_d_wx_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_best_r      <= best_nxt;
      b_tag_r.n     <= n_nxt;
      b_tag_r.degen <= (best_nxt == '0);
      b_tag_r.piv   <= (best_nxt == '0) ? PIV_X : piv_nxt;
    end
  end

  // ---------------- Square root: p = floor(sqrt(best * 4096)) ---------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sqrt_tag_t         sq_tag;

  rmq_sqrt_pipe #(
    .TAG_W ($bits(sqrt_tag_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (b_vld_r),
    .in_rad   ({1'b0, b_best_r, 12'b0}),
    .in_tag   (b_tag_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // ---------------- Division: lanes times 4096 over p -----------------------
  div_tag_t dv_tag_in;
  logic     dv_vld;
  logic signed [LANES-1:0][Q_W-1:0] dv_q;
  div_tag_t dv_tag;

  assign dv_tag_in.piv   = sq_tag.piv;
  assign dv_tag_in.degen = sq_tag.degen;
  assign dv_tag_in.p     = sq_root;

  rmq_div_pipe #(
    .TAG_W ($bits(div_tag_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .in_n    (sq_tag.n),
    .in_p    (sq_root),
    .in_tag  (dv_tag_in),
    .out_vld (dv_vld),
    .out_q   (dv_q),
    .out_tag (dv_tag)
  );

  // ---------------- Output register: map lanes back, zero if degenerate -----
  logic signed [Q_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic [1:0]            piv_r;
  logic                  degen_r;

  logic signed [Q_W-1:0] pc;
  logic signed [Q_W-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;

  assign pc = signed'({1'b0, dv_tag.p});

  always_comb begin
    unique case (dv_tag.piv)
      PIV_X: begin
        qw_nxt = dv_q[2]; qx_nxt = pc;      qy_nxt = dv_q[0]; qz_nxt = dv_q[1];
      end
      PIV_Y: begin
        qw_nxt = dv_q[2]; qx_nxt = dv_q[0]; qy_nxt = pc;      qz_nxt = dv_q[1];
      end
      PIV_Z: begin
        qw_nxt = dv_q[2]; qx_nxt = dv_q[0]; qy_nxt = dv_q[1]; qz_nxt = pc;
      end
      default: begin
        qw_nxt = pc;      qx_nxt = dv_q[0]; qy_nxt = dv_q[1]; qz_nxt = dv_q[2];
      end
    endcase
    if (dv_tag.degen) begin
      qw_nxt = '0;
      qx_nxt = '0;
      qy_nxt = '0;
      qz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r    <= qw_nxt;
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      qz_r    <= qz_nxt;
      piv_r   <= dv_tag.piv;
      degen_r <= dv_tag.degen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quat_w      = qw_r;
  assign out_quat_x      = qx_r;
  assign out_quat_y      = qy_r;
  assign out_quat_z      = qz_r;
  assign out_pivot_index = piv_r;
  assign out_degenerate  = degen_r;

  // ---------------- Checks --------------------------------------------------
  logic signed [Q_W-1:0] piv_q;
  always_comb begin
    unique case (piv_r)
      PIV_X:   piv_q = qx_r;
      PIV_Y:   piv_q = qy_r;
      PIV_Z:   piv_q = qz_r;
      default: piv_q = qw_r;
    endcase
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && degen_r) |-> (qw_r == '0 && qx_r == '0 && qy_r == '0 && qz_r == '0))
    else $error("degenerate result carries a nonzero component");

  a_degen_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && degen_r) |-> (piv_r == PIV_X))
    else $error("degenerate result carries a pivot other than x");

  a_pivot_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !degen_r) |-> (piv_q >= 16'sd64))
    else $error("pivot component below the minimum root");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while the output is held");

endmodule
`default_nettype wire
